[hw/rtl/bus_hold_owner_set_assert.svh]
// Assertion macros shared by the RTL.
`ifndef BUS_HOLD_OWNER_SET_ASSERT_SVH
`define BUS_HOLD_OWNER_SET_ASSERT_SVH

`ifndef ASSERT_OFF

`define BHOS_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bhos assertion failed");

`define BHOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhos assertion failed");

`else

`define BHOS_ASSERT(label, clk, rst_n, expr)

`define BHOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/bhos_pkg.sv]
`default_nettype none

package bhos_pkg;

    localparam int FUNC_W     = 2;
    localparam int OWNER_W    = 8;
    localparam int COUNT_W    = 4;
    localparam int TOTAL_W    = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RELEASE = 2'd0,
        FUNC_HOLD    = 2'd1,
        FUNC_ACK     = 2'd2
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [OWNER_W-1:0] owner_id;
    } in_word_t;

    typedef struct packed {
        logic               changed;
        logic               rejected;
        logic               held;
        logic               acked;
        logic [COUNT_W-1:0] holder_count;
        logic [TOTAL_W-1:0] hold_total;
        logic [TOTAL_W-1:0] release_total;
        logic [TOTAL_W-1:0] overflow_total;
    } out_word_t;

    typedef struct packed {
        logic     valid;
        in_word_t word;
    } stage_t;

endpackage

`default_nettype wire

[hw/rtl/bhos_in_reg.sv]
`default_nettype none

module bhos_in_reg
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire bhos_pkg::in_word_t req_word,
    input  wire logic               out_ready,
    output logic                    advance,
    output bhos_pkg::stage_t        stage
);

    logic               valid_reg;
    logic               valid_next;
    bhos_pkg::in_word_t word_reg;
    logic               accept;

    assign advance   = valid_reg && out_ready;
    assign req_stall = valid_reg && !out_ready;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= req_word;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

`default_nettype wire

[hw/rtl/bhos_core.sv]
`default_nettype none

`include "bus_hold_owner_set_assert.svh"

module bhos_core
#(
    parameter int MAX_HOLDERS = 8,
    parameter int OWNER_BITS  = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bhos_pkg::stage_t stage,
    input  wire logic             advance,
    output bhos_pkg::out_word_t   result
);

    localparam int CW = $clog2(MAX_HOLDERS + 1);

    logic [OWNER_BITS-1:0]               slot_reg   [MAX_HOLDERS];
    logic [OWNER_BITS-1:0]               slot_next  [MAX_HOLDERS];
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic [bhos_pkg::TOTAL_W-1:0]        hold_reg;
    logic [bhos_pkg::TOTAL_W-1:0]        hold_next;
    logic [bhos_pkg::TOTAL_W-1:0]        release_reg;
    logic [bhos_pkg::TOTAL_W-1:0]        release_next;
    logic [bhos_pkg::TOTAL_W-1:0]        overflow_reg;
    logic [bhos_pkg::TOTAL_W-1:0]        overflow_next;
    logic                                ack_reg;
    logic                                ack_next;

    logic [OWNER_BITS-1:0]  owner;
    logic [MAX_HOLDERS-1:0] match;
    logic [MAX_HOLDERS-1:0] at_or_above;
    logic                   present;
    logic                   full;
    logic                   null_owner;
    logic                   is_hold;
    logic                   is_release;
    logic                   is_ack;
    logic                   do_add;
    logic                   do_overflow;
    logic                   do_release;

    assign owner      = OWNER_BITS'(stage.word.owner_id);
    assign null_owner = (owner == '0);
    assign is_hold    = (stage.word.func == bhos_pkg::FUNC_HOLD);
    assign is_release = (stage.word.func == bhos_pkg::FUNC_RELEASE);
    assign is_ack     = (stage.word.func == bhos_pkg::FUNC_ACK);
    assign full       = (count_reg == CW'(MAX_HOLDERS));

    // Unused slots hold zero, so for a non-null owner only live entries can
    // match; owners are unique so at most one bit is set.
    always_comb
    begin
        for (int i = 0; i < MAX_HOLDERS; i++)
        begin
            match[i] = (slot_reg[i] == owner);
        end
    end

    always_comb
    begin
        at_or_above[0] = match[0];
        for (int i = 1; i < MAX_HOLDERS; i++)
        begin
            at_or_above[i] = at_or_above[i-1] | match[i];
        end
    end

    assign present     = |match;
    assign do_add      = is_hold && !null_owner && !present && !full;
    assign do_overflow = is_hold && !null_owner && !present && full;
    assign do_release  = is_release && !null_owner && present;

    for (genvar g = 0; g < MAX_HOLDERS; g++)
    begin : g_slot
        logic [OWNER_BITS-1:0] upper;
        if (g < MAX_HOLDERS - 1)
        begin : g_shift
            assign upper = slot_reg[g+1];
        end
        else
        begin : g_last
            assign upper = '0;
        end

        always_comb
        begin
            slot_next[g] = slot_reg[g];
            if (do_release && at_or_above[g])
            begin
                slot_next[g] = upper;
            end
            else if (do_add && (count_reg == CW'(g)))
            begin
                slot_next[g] = owner;
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        hold_next     = hold_reg;
        release_next  = release_reg;
        overflow_next = overflow_reg;
        ack_next      = ack_reg;
        if (do_add)
        begin
            count_next = count_reg + CW'(1);
            hold_next  = hold_reg + 32'd1;
        end
        if (do_overflow)
        begin
            overflow_next = overflow_reg + 32'd1;
        end
        if (do_release)
        begin
            count_next   = count_reg - CW'(1);
            release_next = release_reg + 32'd1;
        end
        if (is_ack)
        begin
            ack_next = 1'b1;
        end
        else if (do_release && (count_reg == CW'(1)))
        begin
            ack_next = 1'b0;
        end
    end

    always_comb
    begin
        result.changed        = (count_reg != '0) != (count_next != '0);
        result.rejected       = ((is_hold || is_release) && null_owner) || do_overflow;
        result.held           = (count_next != '0);
        result.acked          = ack_next;
        result.holder_count   = bhos_pkg::COUNT_W'(count_next);
        result.hold_total     = hold_next;
        result.release_total  = release_next;
        result.overflow_total = overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_HOLDERS; i++)
            begin
                slot_reg[i] <= '0;
            end
            count_reg    <= '0;
            hold_reg     <= '0;
            release_reg  <= '0;
            overflow_reg <= '0;
            ack_reg      <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < MAX_HOLDERS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
            count_reg    <= count_next;
            hold_reg     <= hold_next;
            release_reg  <= release_next;
            overflow_reg <= overflow_next;
            ack_reg      <= ack_next;
        end
    end

    `BHOS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_HOLDERS))
    `BHOS_ASSERT(a_match_unique, clk, rst_n, !stage.valid || null_owner || $onehot0(match))
    `BHOS_ASSERT_NEXT(a_last_release_clears_ack, clk, rst_n, advance && do_release && (count_reg == CW'(1)), !ack_reg && (count_reg == '0))
    `BHOS_ASSERT_NEXT(a_add_grows, clk, rst_n, advance && do_add, count_reg == $past(count_reg) + CW'(1))

endmodule

`default_nettype wire

[hw/rtl/bhos_out_reg.sv]
`default_nettype none

`include "bus_hold_owner_set_assert.svh"

module bhos_out_reg
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire bhos_pkg::out_word_t result,
    output logic                     out_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output bhos_pkg::out_word_t      rsp_word
);

    logic                valid_reg;
    logic                valid_next;
    bhos_pkg::out_word_t word_reg;

    assign out_ready = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_word  = word_reg;

    `BHOS_ASSERT(a_load_only_when_free, clk, rst_n, !load || out_ready)
    `BHOS_ASSERT_NEXT(a_drain_empties, clk, rst_n, valid_reg && !rsp_stall && !load, !valid_reg)

endmodule

`default_nettype wire

[hw/rtl/bus_hold_owner_set.sv]
// Bus hold owner set.
// Request channel: req_valid / req_stall / req_word carry one word with an
// operation (release, hold, poller acknowledge) and an owner identifier.
// Response channel: rsp_valid / rsp_stall / rsp_word carry one word per
// request with the changed and rejected flags, held and acked status, the
// holder count and the three wrapping 32-bit totals.
// A word is taken at a rising edge with valid high and stall low.
// A request taken sits in the input register; when it advances it is applied
// to the owner set and its response is loaded into the response register.
// Throughput: one request per cycle while rsp_stall is low; the set lookup,
// compaction and counter updates are one pass of logic between the input and
// response registers. When rsp_stall holds, the response register keeps its
// word, the request in the input register waits, and req_stall rises until
// the response is taken. Reset (rst_n low, asynchronous) empties the set,
// clears the acknowledge flag, zeroes all totals and drops both valid flags;
// no clearing pass is needed, so requests are taken right after reset.
`default_nettype none

module bus_hold_owner_set
#(
    parameter int MAX_HOLDERS = 8,
    parameter int OWNER_BITS  = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire bhos_pkg::in_word_t  req_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output bhos_pkg::out_word_t      rsp_word
);

    bhos_pkg::stage_t    stage;
    bhos_pkg::out_word_t result;
    logic                out_ready;
    logic                advance;

    bhos_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .out_ready (out_ready),
        .advance   (advance),
        .stage     (stage)
    );

    bhos_core
    #(
        .MAX_HOLDERS (MAX_HOLDERS),
        .OWNER_BITS  (OWNER_BITS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    bhos_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .out_ready (out_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire
